>>> rtl/tot_pkg.sv
package tot_pkg;

    localparam int ENTRIES       = 64;
    localparam int SHADOW_BYTES  = 4096;
    localparam int MAX_BYTES     = 8;
    localparam int INT_REGS      = 33;
    localparam int FP_REGS       = 32;
    localparam int PC_TAINT_REG  = 32;

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int NB_W     = $clog2(MAX_BYTES + 1);
    localparam int MEM_AW   = $clog2(SHADOW_BYTES);
    localparam int SH_DEPTH = SHADOW_BYTES + INT_REGS + FP_REGS;
    localparam int SH_AW    = $clog2(SH_DEPTH);
    localparam int INT_BASE = SHADOW_BYTES;
    localparam int FP_BASE  = SHADOW_BYTES + INT_REGS;

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_DELETE = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_PROP   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [1:0] SP_MEM   = 2'd0;
    localparam logic [1:0] SP_INT   = 2'd1;
    localparam logic [1:0] SP_FP    = 2'd2;
    localparam logic [1:0] SP_INSTR = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BAD_SPACE = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  space;
        logic [31:0] location;
        logic [31:0] pc;
        logic [31:0] start_pc;
        logic [31:0] end_pc;
        logic [63:0] colour_a;
        logic [63:0] colour_b;
        logic [3:0]  byte_count;
    } t_in_item;

    typedef struct packed {
        logic [63:0] colour;
        logic [2:0]  status;
        logic        duplicate;
    } t_out_item;

    typedef struct packed {
        logic [31:0] loc;
        logic [1:0]  sp;
        logic [31:0] start_pc;
        logic [31:0] end_pc;
        logic [63:0] colour;
    } t_entry;

    // query token walking down the cell row
    typedef struct packed {
        logic             valid;
        logic [31:0]      loc;
        logic [1:0]       sp;
        logic [31:0]      pc;
        logic [31:0]      start_pc;
        logic [31:0]      end_pc;
        logic             hit;
        logic [63:0]      acc;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_tok;

    typedef struct packed {
        logic             ins;
        logic [IDX_W-1:0] ins_idx;
        t_entry           entry;
        logic             del;
        logic [IDX_W-1:0] del_idx;
    } t_ctl;

    function automatic logic [SH_AW-1:0] sh_index(logic [1:0] sp, logic [31:0] loc,
                                                  logic [31:0] base);
        logic [31:0] off;
        off = loc - base;
        if (sp == SP_MEM)
            return SH_AW'(off[MEM_AW-1:0]);
        else if (sp == SP_INT)
            return SH_AW'(INT_BASE) + SH_AW'(loc[5:0]);
        else
            return SH_AW'(FP_BASE) + SH_AW'(loc[4:0]);
    endfunction

endpackage

>>> rtl/tot_cell.sv
module tot_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tot_pkg::IDX_W-1:0]   i_index,
    input  tot_pkg::t_ctl               i_ctl,
    input  tot_pkg::t_tok               i_tok,
    input  tot_pkg::t_entry             i_next,
    input  logic                        i_next_valid,
    output tot_pkg::t_tok               o_tok,
    output tot_pkg::t_entry             o_entry,
    output logic                        o_valid
);
    import tot_pkg::*;

    t_entry r_entry;
    logic   r_valid;
    t_tok   r_tok;
    t_tok   n_tok;
    logic   w_key;
    logic   w_exact;
    logic   w_win;
    logic   w_shift;
    logic   w_load;

    always_comb begin
        w_key   = r_valid && r_entry.loc == i_tok.loc && r_entry.sp == i_tok.sp;
        w_exact = w_key && r_entry.start_pc == i_tok.start_pc
                        && r_entry.end_pc == i_tok.end_pc;
        w_win   = w_key && r_entry.start_pc <= i_tok.pc && i_tok.pc <= r_entry.end_pc;
        w_shift = i_ctl.del && i_index >= i_ctl.del_idx;
        w_load  = i_ctl.ins && i_ctl.ins_idx == i_index;
    end

    always_comb begin
        n_tok = i_tok;
        if (w_win) begin
            n_tok.hit = 1'b1;
            n_tok.acc = i_tok.acc | r_entry.colour;
        end
        // later cells override: last exact match wins
        if (w_exact) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_shift)
                r_valid <= i_next_valid;
            else if (w_load)
                r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift)
            r_entry <= i_next;
        else if (w_load)
            r_entry <= i_ctl.entry;
    end

    assign o_tok   = r_tok;
    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

>>> rtl/tot_shadow_ram.sv
module tot_shadow_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [tot_pkg::SH_AW-1:0]  i_waddr,
    input  logic [63:0]                i_wdata,
    input  logic [tot_pkg::SH_AW-1:0]  i_raddr,
    output logic [63:0]                o_rdata
);
    import tot_pkg::*;

    logic [63:0] r_mem [SH_DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/taint_origin_table_with_shadow_top.sv
// Taint origin table with shadow colours. After reset the block zeroes the
// shadow memory (memory bytes, then 33 integer registers, then 32 float
// registers) and holds o_stall high meanwhile; configuration writes are
// taken at any time. One transaction is in flight at a time. Propagate,
// clear, bad-space, out-of-range, full-table and unknown mode transactions
// go from the check state straight to the result. Insert, read and delete
// send query tokens down the row of 64 origin cells, one cell per cycle:
// one per addressed byte for memory insert and read, else one; insert then
// writes an entry per byte. The origin row is the rate-setting path.
module taint_origin_table_with_shadow_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  tot_pkg::t_in_item    i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output tot_pkg::t_out_item   o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_data
);
    import tot_pkg::*;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_CHECK, S_SCAN, S_UPD, S_OUT
    } t_state;

    t_state           r_state;
    t_in_item         r_req;
    t_out_item        r_out;
    logic [31:0]      r_base;
    logic [63:0]      r_pc_taint;
    logic [SH_AW-1:0] r_clr;
    logic [NB_W-1:0]  r_n;
    logic [NB_W-1:0]  r_feed;
    logic [NB_W-1:0]  r_exit;
    logic [NB_W-1:0]  r_ins;
    logic             r_rd_pend;
    logic             r_ex_hit;
    logic [63:0]      r_ex_acc;
    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;

    // check stage
    logic [NB_W-1:0]  w_nb;
    logic [NB_W-1:0]  w_n;
    logic             w_range_bad;
    logic             w_full;
    logic [31:0]      w_off;

    // shadow ram ports
    logic             w_we;
    logic [SH_AW-1:0] w_waddr;
    logic [63:0]      w_wdata;
    logic [SH_AW-1:0] w_raddr;
    logic [63:0]      w_rdata;

    // origin row
    t_tok             w_tok [ENTRIES+1];
    t_entry           w_ent [ENTRIES];
    logic             w_vld [ENTRIES];
    t_ctl             w_ctl;
    t_tok             w_tail;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_out       = r_out;
    assign w_tail      = w_tok[ENTRIES];

    // byte count: zero acts as one, saturate at the maximum
    always_comb begin
        if (r_req.byte_count == 4'd0)
            w_nb = NB_W'(1);
        else if (32'(r_req.byte_count) > 32'(MAX_BYTES))
            w_nb = NB_W'(MAX_BYTES);
        else
            w_nb = NB_W'(r_req.byte_count);
        if (r_req.space == SP_MEM && (r_req.mode == MODE_INSERT || r_req.mode == MODE_READ))
            w_n = w_nb;
        else
            w_n = NB_W'(1);

        w_range_bad = 1'b0;
        for (int b = 0; b < MAX_BYTES; b++) begin
            w_off = r_req.location + 32'(b) - r_base;
            if (NB_W'(b) < w_n) begin
                if (r_req.space == SP_MEM && w_off >= 32'(SHADOW_BYTES))
                    w_range_bad = 1'b1;
                if (r_req.space == SP_INT && r_req.location >= 32'(INT_REGS))
                    w_range_bad = 1'b1;
                if (r_req.space == SP_FP && r_req.location >= 32'(FP_REGS))
                    w_range_bad = 1'b1;
            end
        end
        w_full = ({1'b0, r_count} + (CNT_W+1)'(w_n)) > (CNT_W+1)'(ENTRIES);
    end

    // shadow writes: clearing sweep, propagate and clear
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        if (r_state == S_CLR) begin
            w_we = 1'b1;
        end else if (r_state == S_CHECK && r_req.mode <= MODE_CLEAR
                     && r_req.space != SP_INSTR && !w_range_bad
                     && (r_req.mode == MODE_PROP || r_req.mode == MODE_CLEAR)) begin
            w_we    = 1'b1;
            w_waddr = sh_index(r_req.space, r_req.location, r_base);
            if (r_req.mode == MODE_PROP)
                w_wdata = r_req.colour_a | r_req.colour_b | r_pc_taint;
        end
        w_raddr = sh_index(w_tail.sp, w_tail.loc, r_base);
    end

    // query token fed at the head of the row, one per byte
    always_comb begin
        w_tok[0]          = '0;
        w_tok[0].valid    = (r_state == S_SCAN) && (r_feed < r_n);
        w_tok[0].loc      = r_req.location + 32'(r_feed);
        w_tok[0].sp       = r_req.space;
        w_tok[0].pc       = r_req.pc;
        w_tok[0].start_pc = r_req.start_pc;
        w_tok[0].end_pc   = r_req.end_pc;
    end

    // row write controls: append on insert, close the gap on delete
    always_comb begin
        w_ctl                = '0;
        w_ctl.ins            = (r_state == S_UPD) && (r_req.mode == MODE_INSERT);
        w_ctl.ins_idx        = r_count[IDX_W-1:0];
        w_ctl.entry.loc      = r_req.location + 32'(r_ins);
        w_ctl.entry.sp       = r_req.space;
        w_ctl.entry.start_pc = r_req.start_pc;
        w_ctl.entry.end_pc   = r_req.end_pc;
        w_ctl.entry.colour   = r_req.colour_a;
        w_ctl.del            = (r_state == S_UPD) && (r_req.mode == MODE_DELETE);
        w_ctl.del_idx        = r_idx;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_entry w_next;
        logic   w_next_valid;
        if (g == ENTRIES - 1) begin : g_last
            assign w_next       = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_mid
            assign w_next       = w_ent[g+1];
            assign w_next_valid = w_vld[g+1];
        end
        tot_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IDX_W'(g)),
            .i_ctl        (w_ctl),
            .i_tok        (w_tok[g]),
            .i_next       (w_next),
            .i_next_valid (w_next_valid),
            .o_tok        (w_tok[g+1]),
            .o_entry      (w_ent[g]),
            .o_valid      (w_vld[g])
        );
    end

    tot_shadow_ram u_shadow (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_base     <= '0;
            r_pc_taint <= '0;
            r_count    <= '0;
            r_rd_pend  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                r_base <= i_cfg_data;
            // keep a copy of the pc taint register for propagate
            if (w_we && w_waddr == SH_AW'(INT_BASE + PC_TAINT_REG))
                r_pc_taint <= w_wdata;

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + SH_AW'(1);
                    if (r_clr == SH_AW'(SH_DEPTH - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_in;
                        r_out   <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_n       <= w_n;
                    r_feed    <= '0;
                    r_exit    <= '0;
                    r_ins     <= '0;
                    r_found   <= 1'b0;
                    r_rd_pend <= 1'b0;
                    if (r_req.mode > MODE_CLEAR) begin
                        r_state <= S_OUT;
                    end else if (r_req.space == SP_INSTR) begin
                        r_out.status <= ST_BAD_SPACE;
                        r_state      <= S_OUT;
                    end else if (w_range_bad) begin
                        r_out.status <= ST_RANGE;
                        r_state      <= S_OUT;
                    end else if (r_req.mode == MODE_PROP) begin
                        r_out.colour <= w_wdata;
                        r_state      <= S_OUT;
                    end else if (r_req.mode == MODE_CLEAR) begin
                        r_state <= S_OUT;
                    end else if (r_req.mode == MODE_INSERT && w_full) begin
                        r_out.status <= ST_FULL;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tok[0].valid)
                        r_feed <= r_feed + NB_W'(1);
                    r_rd_pend <= w_tail.valid;
                    if (w_tail.valid) begin
                        r_exit   <= r_exit + NB_W'(1);
                        r_ex_hit <= w_tail.hit;
                        r_ex_acc <= w_tail.acc;
                        if (w_tail.found) begin
                            r_found         <= 1'b1;
                            r_idx           <= w_tail.idx;
                            r_out.duplicate <= (r_req.mode == MODE_INSERT);
                        end
                    end
                    // matched origins win over the shadow value
                    if (r_rd_pend && r_req.mode == MODE_READ)
                        r_out.colour <= r_out.colour | (r_ex_hit ? r_ex_acc : w_rdata);
                    if (r_exit == r_n && !r_rd_pend) begin
                        if (r_req.mode == MODE_READ) begin
                            r_state <= S_OUT;
                        end else if (r_req.mode == MODE_DELETE && !r_found) begin
                            r_out.status <= ST_NOT_FOUND;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    if (r_req.mode == MODE_INSERT) begin
                        r_count <= r_count + CNT_W'(1);
                        r_ins   <= r_ins + NB_W'(1);
                        if (r_ins == r_n - NB_W'(1))
                            r_state <= S_OUT;
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // table fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("origin count beyond table depth");

    // nothing is taken while the shadow sweep runs
    a_clr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> o_stall && !o_valid)
        else $error("transaction during shadow clearing");

    // a successful delete removes exactly one origin
    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD && r_req.mode == MODE_DELETE
        |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("delete did not shrink the table by one");

endmodule
